// ===== design/tcst_pkg.sv =====
// Package: shared types, sizes and codes for the timed command schedule table.
package tcst_pkg;

    localparam int DEPTH        = 16;
    localparam int TIME_BITS    = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CHECK  = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [TIME_BITS-1:0]    new_time;
        logic [PAYLOAD_BITS-1:0] new_payload;
        logic [7:0]              id_first;
        logic [7:0]              id_second;
        logic [TIME_BITS-1:0]    now_time;
        logic                    now_valid;
        logic [CNT_BITS-1:0]     first_index;
        logic [CNT_BITS-1:0]     end_index;
    } t_req;

    typedef struct packed {
        logic                    accepted;
        logic                    due;
        logic [TIME_BITS-1:0]    head_time;
        logic [PAYLOAD_BITS-1:0] head_payload;
        logic [CNT_BITS-1:0]     entry_count;
    } t_rsp;

    typedef struct packed {
        logic                    occ;
        logic [TIME_BITS-1:0]    etime;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [1:0]              op;
        logic [TIME_BITS-1:0]    etime;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [IDX_BITS-1:0]     first;
    } t_cell_ctrl;

endpackage

// ===== design/timed_command_schedule_table_top.sv =====
// Top level: request decode, removal sequencer, cell chain and result register.
//
//   channel   signals                                     payload
//   request   i_in_valid / o_in_ready                     i_in_req  (tcst_pkg::t_req)
//   result    o_out_valid / i_out_ready                   o_out_rsp (tcst_pkg::t_rsp)
//
// Add, check, rejected remove and unused kinds go via S_FIN to the result register.
// A valid remove first passes through S_REMOVE, where the cell chain drops one
// slot per cycle and shifts the tail left by one, then goes on to S_FIN.
// Reset empties every slot at once; no clearing pass is needed.
// A result waiting on i_out_ready holds the block after the next command finishes.
module timed_command_schedule_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcst_pkg::t_req  i_in_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tcst_pkg::t_rsp  o_out_rsp
);
    import tcst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_FIN    = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [CNT_BITS-1:0] r_left, n_left;
    logic [IDX_BITS-1:0] r_first, n_first;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                r_acc, n_acc;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_rsp, n_rsp;

    t_cell_ctrl          ctrl;
    t_entry              cell_q [DEPTH];
    logic                cell_le [DEPTH];
    logic [DEPTH-1:0]    occ_vec;

    logic in_fire;
    logic add_ok;
    logic rem_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    assign add_ok = (i_in_req.id_first != 8'd0) && (i_in_req.id_first == i_in_req.id_second)
                 && (r_count < CNT_BITS'(DEPTH)) && i_in_req.now_valid
                 && (i_in_req.new_time != '0) && (i_in_req.new_time >= i_in_req.now_time);
    assign rem_ok = (i_in_req.first_index < i_in_req.end_index)
                 && (i_in_req.end_index <= r_count);

    always_comb begin
        ctrl.op      = OP_HOLD;
        ctrl.etime   = i_in_req.new_time;
        ctrl.payload = i_in_req.new_payload;
        ctrl.first   = r_first;
        if (in_fire && (i_in_req.kind == KIND_ADD) && add_ok) begin
            ctrl.op = OP_INS;
        end else if (r_state == S_REMOVE) begin
            ctrl.op = OP_DEL;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_e;
            t_entry right_e;
            logic   left_le;
            if (g == 0) begin : g_head
                assign left_e  = '0;
                assign left_le = 1'b1;
            end else begin : g_mid
                assign left_e  = cell_q[g-1];
                assign left_le = cell_le[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_e = '0;
            end else begin : g_body
                assign right_e = cell_q[g+1];
            end
            tcst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_index   (IDX_BITS'(g)),
                .i_ctrl    (ctrl),
                .i_left    (left_e),
                .i_left_le (left_le),
                .i_right   (right_e),
                .o_entry   (cell_q[g]),
                .o_le      (cell_le[g])
            );
            assign occ_vec[g] = cell_q[g].occ;
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_first     = r_first;
        n_now       = r_now;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rsp       = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_now   = i_in_req.now_time;
                    n_acc   = 1'b0;
                    n_state = S_FIN;
                    if (i_in_req.kind == KIND_ADD && add_ok) begin
                        n_acc   = 1'b1;
                        n_count = r_count + 1'b1;
                    end else if (i_in_req.kind == KIND_REMOVE && rem_ok) begin
                        n_acc   = 1'b1;
                        n_first = i_in_req.first_index[IDX_BITS-1:0];
                        n_left  = i_in_req.end_index - i_in_req.first_index;
                        n_state = S_REMOVE;
                    end
                end
            end
            S_REMOVE: begin
                // drop one slot per cycle at the same index
                n_count = r_count - 1'b1;
                n_left  = r_left - 1'b1;
                if (r_left == CNT_BITS'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_rsp.accepted     = r_acc;
                    n_rsp.due          = cell_q[0].occ && (cell_q[0].etime <= r_now);
                    n_rsp.head_time    = cell_q[0].etime;
                    n_rsp.head_payload = cell_q[0].payload;
                    n_rsp.entry_count  = r_count;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_now   <= n_now;
        r_acc   <= n_acc;
        r_rsp   <= n_rsp;
    end

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_REMOVE) |-> ($countones(occ_vec) == 32'(r_count)))
        else $error("entry count disagrees with occupied cells");

    a_head_when_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (cell_q[0].occ == (r_count != '0)))
        else $error("head cell occupancy disagrees with count");

    a_remove_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> (r_left != '0) && (r_count != '0))
        else $error("remove sequencer ran past its range");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire) |=> (r_state == S_FIN || r_state == S_REMOVE))
        else $error("accepted request did not start execution");

endmodule

// ===== design/tcst_cell.sv =====
// One slot of the sorted table: holds an entry and shifts with its neighbors.
module tcst_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [tcst_pkg::IDX_BITS-1:0] i_index,
    input  tcst_pkg::t_cell_ctrl  i_ctrl,
    input  tcst_pkg::t_entry      i_left,
    input  logic                  i_left_le,
    input  tcst_pkg::t_entry      i_right,
    output tcst_pkg::t_entry      o_entry,
    output logic                  o_le
);
    import tcst_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Entry stays ahead of a new one with equal time, which keeps arrival order.
    assign o_le    = r_entry.occ && (r_entry.etime <= i_ctrl.etime);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            OP_INS: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_entry.occ     = 1'b1;
                        n_entry.etime   = i_ctrl.etime;
                        n_entry.payload = i_ctrl.payload;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            OP_DEL: begin
                // close the gap: everything from the removed slot on moves left
                if (i_index >= i_ctrl.first) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== sim/timed_command_schedule_table_top_test.sv =====
// Testbench for the timed command schedule table: directed table plus random requests.
module timed_command_schedule_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcst_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int N_DIR      = 20;
    localparam int N_PHASES   = 9;
    localparam int PHASE_LEN  = 60;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 24;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_rsp;

    timed_command_schedule_table_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predicted table contents, kept in sorted order.
    logic [TIME_BITS-1:0]    tab_time [DEPTH];
    logic [PAYLOAD_BITS-1:0] tab_pay  [DEPTH];
    int unsigned             tab_cnt;

    t_rsp status_q [$];
    int   mismatches = 0;
    bit   calm = 1'b0;
    int   ready_left = 0;
    int   idle_cycles = 0;
    logic [TIME_BITS-1:0] cur_now;
    t_stim_row dir_tab [N_DIR];

    int n_req = 0, n_stored = 0, n_full_rej = 0, n_removed = 0, n_due = 0, n_results = 0;
    int peak_cnt = 0;

    function automatic t_rsp schedule_step(input t_req r);
        t_rsp        rsp;
        bit          ok;
        int unsigned pos;
        int unsigned num;
        ok = 1'b0;
        n_req++;
        case (r.kind)
            KIND_ADD: begin
                if (tab_cnt >= DEPTH)
                    n_full_rej++;
                if (r.id_first != 0 && r.id_first == r.id_second && tab_cnt < DEPTH &&
                    r.now_valid && r.new_time != 0 && r.new_time >= r.now_time) begin
                    // equal times stay in arrival order
                    pos = 0;
                    while (pos < tab_cnt && tab_time[pos] <= r.new_time)
                        pos++;
                    for (int k = tab_cnt; k > pos; k--) begin
                        tab_time[k] = tab_time[k-1];
                        tab_pay[k]  = tab_pay[k-1];
                    end
                    tab_time[pos] = r.new_time;
                    tab_pay[pos]  = r.new_payload;
                    tab_cnt++;
                    ok = 1'b1;
                    n_stored++;
                end
            end
            KIND_REMOVE: begin
                if (r.first_index < r.end_index && r.end_index <= tab_cnt) begin
                    num = r.end_index - r.first_index;
                    for (int k = r.end_index; k < tab_cnt; k++) begin
                        tab_time[k-num] = tab_time[k];
                        tab_pay[k-num]  = tab_pay[k];
                    end
                    for (int k = tab_cnt - num; k < tab_cnt; k++) begin
                        tab_time[k] = '0;
                        tab_pay[k]  = '0;
                    end
                    tab_cnt -= num;
                    ok = 1'b1;
                    n_removed++;
                end
            end
            default: ;
        endcase
        rsp = '0;
        rsp.accepted = ok;
        if (tab_cnt > 0) begin
            rsp.due          = (tab_time[0] <= r.now_time);
            rsp.head_time    = tab_time[0];
            rsp.head_payload = tab_pay[0];
        end
        rsp.entry_count = CNT_BITS'(tab_cnt);
        if (rsp.due)
            n_due++;
        if (tab_cnt > peak_cnt)
            peak_cnt = tab_cnt;
        return rsp;
    endfunction

    function automatic t_req mk_req(input logic [1:0] kind, input logic [31:0] t,
                                    input logic [31:0] p, input logic [7:0] a,
                                    input logic [7:0] b, input logic [31:0] now,
                                    input logic v, input logic [4:0] f, input logic [4:0] e);
        t_req r;
        r.kind        = kind;
        r.new_time    = t;
        r.new_payload = p;
        r.id_first    = a;
        r.id_second   = b;
        r.now_time    = now;
        r.now_valid   = v;
        r.first_index = f;
        r.end_index   = e;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mode 0 fills the table, mode 1 drains it, mode 2 mixes.
    function automatic t_req random_req(input int mode);
        t_req        r;
        int unsigned roll;
        int unsigned add_pct;
        int unsigned span;
        r.kind        = 2'($urandom());
        r.new_time    = $urandom();
        r.new_payload = $urandom();
        r.id_first    = 8'($urandom());
        r.id_second   = 8'($urandom());
        r.now_time    = $urandom();
        r.now_valid   = 1'($urandom());
        r.first_index = 5'($urandom());
        r.end_index   = 5'($urandom());
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return r;
        add_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            r.kind      = KIND_ADD;
            r.id_first  = 8'($urandom_range(1, 255));
            r.id_second = r.id_first;
            r.now_valid = 1'b1;
            r.now_time  = cur_now;
            r.new_time  = ($urandom_range(0, 7) == 0) ? cur_now
                                                       : cur_now + $urandom_range(0, 300);
            // break one condition now and then
            case ($urandom_range(0, 19))
                0: r.id_second = r.id_first ^ 8'($urandom_range(1, 255));
                1: begin
                    r.id_first  = '0;
                    r.id_second = '0;
                end
                2: r.now_valid = 1'b0;
                3: r.new_time = (cur_now > 1) ? cur_now - $urandom_range(1, cur_now - 1) : '0;
                4: r.new_time = '0;
                default: ;
            endcase
        end else if (roll < add_pct + (100 - add_pct) / 2) begin
            r.kind     = KIND_CHECK;
            cur_now    = cur_now + $urandom_range(0, 150);
            r.now_time = cur_now;
        end else begin
            r.kind = KIND_REMOVE;
            if (tab_cnt > 0 && $urandom_range(0, 99) < 85) begin
                r.first_index = 5'($urandom_range(0, tab_cnt - 1));
                span = tab_cnt - 1 - r.first_index;
                if (span > 3)
                    span = 3;
                r.end_index = r.first_index + 5'(1 + $urandom_range(0, span));
            end
        end
        return r;
    endfunction

    task automatic send_req(input t_req r, input bit typed, input t_rsp fixed);
        int   gap;
        t_rsp pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pred = schedule_step(r);
        status_q.push_back(typed ? fixed : pred);
    endtask

    // Hold the request side until every result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (status_q.size() != 0);
    endtask

    // Result side: runs of ready, and stalls mostly short, a few long.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (calm) begin
            i_out_ready <= 1'b1;
            ready_left  <= 8;
        end else if ($urandom_range(0, 99) < 60) begin
            i_out_ready <= 1'b1;
            ready_left  <= $urandom_range(1, 12);
        end else begin
            i_out_ready <= 1'b0;
            ready_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (status_q.size() == 0) begin
                $error("unexpected result: %p", o_out_rsp);
                mismatches++;
            end else begin
                want = status_q.pop_front();
                if (o_out_rsp.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_out_rsp.accepted);
                    mismatches++;
                end
                if (o_out_rsp.due !== want.due) begin
                    $error("due: expected %0d, got %0d", want.due, o_out_rsp.due);
                    mismatches++;
                end
                if (o_out_rsp.head_time !== want.head_time) begin
                    $error("head_time: expected %h, got %h", want.head_time,
                           o_out_rsp.head_time);
                    mismatches++;
                end
                if (o_out_rsp.head_payload !== want.head_payload) begin
                    $error("head_payload: expected %h, got %h", want.head_payload,
                           o_out_rsp.head_payload);
                    mismatches++;
                end
                if (o_out_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           o_out_rsp.entry_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, status_q.size());
            $display("timed_command_schedule_table_top_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        localparam t_rsp RSP_EMPTY = '0;
        localparam t_rsp RSP_FIRST = '{accepted: 1'b1, due: 1'b0, head_time: 32'd100,
                                       head_payload: 32'h0000_aaaa, entry_count: 5'd1};
        localparam t_rsp RSP_WIPED = '{accepted: 1'b1, due: 1'b0, head_time: 32'd0,
                                       head_payload: 32'd0, entry_count: 5'd0};
        t_rsp none;
        none = '0;
        tab_cnt = 0;
        for (int k = 0; k < DEPTH; k++) begin
            tab_time[k] = '0;
            tab_pay[k]  = '0;
        end

        dir_tab[0]  = '{mk_req(KIND_CHECK, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[1]  = '{mk_req(KIND_ADD, 50, 1, 8'd5, 8'd6, 0, 1, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[2]  = '{mk_req(KIND_ADD, 50, 1, 0, 0, 0, 1, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[3]  = '{mk_req(KIND_ADD, 0, 1, 8'd7, 8'd7, 0, 1, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[4]  = '{mk_req(KIND_ADD, 5, 1, 8'd3, 8'd3, 0, 0, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[5]  = '{mk_req(KIND_ADD, 10, 1, 8'd9, 8'd9, 20, 1, 0, 0), 1'b1, RSP_EMPTY};
        dir_tab[6]  = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 0, 1), 1'b1, RSP_EMPTY};
        dir_tab[7]  = '{mk_req(KIND_UNUSED, 5, 1, 8'd1, 8'd1, 0, 1, 0, 1), 1'b1, RSP_EMPTY};
        dir_tab[8]  = '{mk_req(KIND_ADD, 100, 32'h0000_aaaa, 8'd1, 8'd1, 50, 1, 0, 0),
                        1'b1, RSP_FIRST};
        dir_tab[9]  = '{mk_req(KIND_ADD, 100, 32'h0000_bbbb, 8'd2, 8'd2, 100, 1, 0, 0),
                        1'b0, none};
        dir_tab[10] = '{mk_req(KIND_ADD, '1, '1, 8'hff, 8'hff, '1, 1, 0, 0), 1'b0, none};
        dir_tab[11] = '{mk_req(KIND_ADD, 60, 0, 8'h80, 8'h80, 60, 1, 0, 0), 1'b0, none};
        dir_tab[12] = '{mk_req(KIND_CHECK, 0, 0, 0, 0, 59, 1, 0, 0), 1'b0, none};
        dir_tab[13] = '{mk_req(KIND_CHECK, 0, 0, 0, 0, '1, 1, 0, 0), 1'b0, none};
        dir_tab[14] = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 1, 3), 1'b0, none};
        dir_tab[15] = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 2, 2), 1'b0, none};
        dir_tab[16] = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 0, 31), 1'b0, none};
        dir_tab[17] = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 31, 0), 1'b0, none};
        // due ignores now_valid
        dir_tab[18] = '{mk_req(KIND_CHECK, 0, 0, 0, 0, 60, 0, 0, 0), 1'b0, none};
        dir_tab[19] = '{mk_req(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 0, 2), 1'b1, RSP_WIPED};

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIR; n++)
            send_req(dir_tab[n].req, dir_tab[n].typed, dir_tab[n].rsp);

        cur_now = $urandom_range(1, 1000);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            calm = (ph == 4);
            for (int n = 0; n < PHASE_LEN; n++)
                send_req(random_req(ph % 3), 1'b0, none);
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d requests, %0d results: %0d adds stored, %0d adds on a full table,",
                 n_req, n_results, n_stored, n_full_rej);
        $display("%0d ranges removed, %0d due reports, peak occupancy %0d",
                 n_removed, n_due, peak_cnt);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("timed_command_schedule_table_top_test: PASS");
        end else begin
            $display("timed_command_schedule_table_top_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcst_pkg.sv
design/tcst_cell.sv
design/timed_command_schedule_table_top.sv
sim/timed_command_schedule_table_top_test.sv
